### rtl/core/feel_pkg.sv
// shared constants, control types and helpers for the flash eeprom emulation log
package feel_pkg;

   localparam int EEPROM_BYTES_DEF = 1024;
   localparam int BANK_BYTES_DEF   = 8192;

   localparam logic [31:0] MAGIC_LO = 32'haa55ee77;
   localparam logic [31:0] MAGIC_HI = 32'h77eeaa55;
   localparam logic [31:0] ERASED   = 32'hffffffff;
   localparam logic [7:0]  LANE_ONES = 8'hff;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] ST_READ      = 2'd0;
   localparam logic [1:0] ST_LOGGED    = 2'd1;
   localparam logic [1:0] ST_SKIPPED   = 2'd2;
   localparam logic [1:0] ST_COMPACTED = 2'd3;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic load;
      logic rd_log;
      logic rd_base;
      logic cur_log;
      logic cur_base;
      logic append;
      logic cp_init;
      logic cp_rd;
      logic cp_base_wr;
      logic cp_log_wr;
      logic cp_new_wr;
      logic cp_seq_wr;
      logic cp_magic_wr;
      logic respond;
   } ctrl_cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic scan_done;
      logic hit;
      logic is_write;
      logic unchanged;
      logic log_full;
      logic cpl_last;
      logic rsp_free;
   } ctrl_stat_type;

   function automatic logic [31:0] byte_mask(input logic [3:0] be);
      logic [31:0] m;
      m = '0;
      for (int k = 0; k < 4; k++) begin
         if (be[k]) m[8*k +: 8] = LANE_ONES;
      end
      return m;
   endfunction

endpackage

### rtl/core/feel_req_if.sv
// request channel: command, word index, write data and byte enables
interface feel_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  word_index;
   logic [31:0] write_data;
   logic [3:0]  byte_enable;

   modport source(output valid, command, word_index, write_data, byte_enable, input ready);
   modport sink(input valid, command, word_index, write_data, byte_enable, output ready);
endinterface

### rtl/core/feel_rsp_if.sv
// response channel: word value and operation status
interface feel_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [1:0]  status;

   modport source(output valid, read_data, status, input ready);
   modport sink(input valid, read_data, status, output ready);
endinterface

### rtl/core/feel_ctrl.sv
// sequencer for lookup, append and bank compaction
module feel_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  feel_pkg::ctrl_stat_type stat,
   output feel_pkg::ctrl_cmd_type  cmd,
   output logic                   req_ready,
   input  logic                   req_valid
);

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_LOG_RD   = 15'b000000000000010,
      S_LOG_CHK  = 15'b000000000000100,
      S_BASE_RD  = 15'b000000000001000,
      S_BASE_CHK = 15'b000000000010000,
      S_DECIDE   = 15'b000000000100000,
      S_APPEND   = 15'b000000001000000,
      S_CPB_RD   = 15'b000000010000000,
      S_CPB_WR   = 15'b000000100000000,
      S_CPL_RD   = 15'b000001000000000,
      S_CPL_WR   = 15'b000010000000000,
      S_CP_NEW   = 15'b000100000000000,
      S_CP_SEQ   = 15'b001000000000000,
      S_CP_MAGIC = 15'b010000000000000,
      S_RESP     = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOG_RD;
            end
         end
         S_LOG_RD: begin
            if (stat.scan_done) begin
               state_in = S_BASE_RD;
            end else begin
               cmd.rd_log = 1'b1;
               state_in   = S_LOG_CHK;
            end
         end
         S_LOG_CHK: begin
            if (stat.hit) begin
               cmd.cur_log = 1'b1;
               state_in    = S_DECIDE;
            end else begin
               state_in = S_LOG_RD;
            end
         end
         S_BASE_RD: begin
            cmd.rd_base = 1'b1;
            state_in    = S_BASE_CHK;
         end
         S_BASE_CHK: begin
            cmd.cur_base = 1'b1;
            state_in     = S_DECIDE;
         end
         S_DECIDE: begin
            if (!stat.is_write || stat.unchanged) begin
               state_in = S_RESP;
            end else if (stat.log_full) begin
               cmd.cp_init = 1'b1;
               state_in    = S_CPB_RD;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_RESP;
         end
         S_CPB_RD: begin
            cmd.cp_rd = 1'b1;
            state_in  = S_CPB_WR;
         end
         S_CPB_WR: begin
            cmd.cp_base_wr = 1'b1;
            state_in       = stat.scan_done ? S_CPL_RD : S_CPB_RD;
         end
         S_CPL_RD: begin
            cmd.cp_rd = 1'b1;
            state_in  = S_CPL_WR;
         end
         S_CPL_WR: begin
            cmd.cp_log_wr = 1'b1;
            state_in      = stat.cpl_last ? S_CP_NEW : S_CPL_RD;
         end
         S_CP_NEW: begin
            cmd.cp_new_wr = 1'b1;
            state_in      = S_CP_SEQ;
         end
         S_CP_SEQ: begin
            cmd.cp_seq_wr = 1'b1;
            state_in      = S_CP_MAGIC;
         end
         S_CP_MAGIC: begin
            cmd.cp_magic_wr = 1'b1;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/feel_dpath.sv
// flash store, bank state, scan and copy counters and response register
module feel_dpath #(
   parameter int EEPROM_BYTES = feel_pkg::EEPROM_BYTES_DEF,
   parameter int BANK_BYTES   = feel_pkg::BANK_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  feel_pkg::ctrl_cmd_type  cmd,
   output feel_pkg::ctrl_stat_type stat,
   feel_req_if.sink                req,
   feel_rsp_if.source              rsp
);

   localparam int WORDS      = EEPROM_BYTES / 4;
   localparam int BASE_SLOTS = EEPROM_BYTES / 8;
   localparam int BANK_SLOTS = BANK_BYTES / 8;
   localparam int LOG_LIMIT  = BANK_SLOTS - 2;
   localparam int SW         = $clog2(BANK_SLOTS);
   localparam int AW         = SW + 1;
   localparam int WW         = $clog2(WORDS);

   logic [63:0] mem [2*BANK_SLOTS];

   logic          bank_ff, bank_in;
   logic [SW-1:0] log_ptr_ff, log_ptr_in;
   logic [31:0]   seq_ff, seq_in;
   logic [1:0]    base_ok_ff, base_ok_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [SW-1:0] cp_ff, cp_in;
   logic          comp_ff, comp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          cmd_ff;
   logic [WW-1:0] w_ff;
   logic [31:0]   wd_ff;
   logic [3:0]    be_ff;
   logic [31:0]   cur_ff, cur_in;
   logic [63:0]   rdata_ff;
   logic [31:0]   rsp_data_ff;
   logic [1:0]    rsp_status_ff;

   logic          other;
   logic [31:0]   mask, nv;
   logic [15:0]   off16;
   logic [SW-1:0] base_idx;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_lo, wr_hi;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data;
   logic [1:0]    rsp_status_in;

   assign other    = ~bank_ff;
   assign mask     = feel_pkg::byte_mask(be_ff);
   assign nv       = (cur_ff & ~mask) | (wd_ff & mask);
   assign off16    = 16'({w_ff, 2'b00});
   assign base_idx = SW'(w_ff >> 1);

   // read port address
   always_comb begin
      rd_en   = cmd.rd_log | cmd.rd_base | cmd.cp_rd;
      rd_addr = {bank_ff, cp_ff};
      if (cmd.rd_log) begin
         rd_addr = {bank_ff, scan_ff - SW'(1)};
      end else if (cmd.rd_base) begin
         rd_addr = {bank_ff, base_idx};
      end
   end

   // write port with half-word enables
   always_comb begin
      wr_lo   = 1'b0;
      wr_hi   = 1'b0;
      wr_addr = {other, cp_ff};
      wr_data = rdata_ff;
      if (cmd.append) begin
         wr_lo   = 1'b1;
         wr_hi   = 1'b1;
         wr_addr = {bank_ff, log_ptr_ff};
         wr_data = {16'h0000, off16, nv};
      end else if (cmd.cp_base_wr) begin
         wr_lo   = 1'b1;
         wr_hi   = 1'b1;
         wr_data = base_ok_ff[bank_ff] ? rdata_ff : {feel_pkg::ERASED, feel_pkg::ERASED};
      end else if (cmd.cp_log_wr) begin
         // replay oldest to newest so the newest slot of a word wins
         wr_lo   = ~rdata_ff[34];
         wr_hi   = rdata_ff[34];
         wr_addr = {other, SW'(rdata_ff[35 +: WW-1])};
         wr_data = {rdata_ff[31:0], rdata_ff[31:0]};
      end else if (cmd.cp_new_wr) begin
         wr_lo   = ~w_ff[0];
         wr_hi   = w_ff[0];
         wr_addr = {other, base_idx};
         wr_data = {nv, nv};
      end else if (cmd.cp_seq_wr) begin
         wr_lo   = 1'b1;
         wr_hi   = 1'b1;
         wr_addr = {other, SW'(LOG_LIMIT)};
         wr_data = {32'h0000_0000, seq_ff + 32'd1};
      end else if (cmd.cp_magic_wr) begin
         wr_lo   = 1'b1;
         wr_hi   = 1'b1;
         wr_addr = {other, SW'(LOG_LIMIT + 1)};
         wr_data = {feel_pkg::MAGIC_HI, feel_pkg::MAGIC_LO};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_lo) mem[wr_addr][31:0]  <= wr_data[31:0];
      if (wr_hi) mem[wr_addr][63:32] <= wr_data[63:32];
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      bank_in      = bank_ff;
      log_ptr_in   = log_ptr_ff;
      seq_in       = seq_ff;
      base_ok_in   = base_ok_ff;
      scan_in      = scan_ff;
      cp_in        = cp_ff;
      comp_in      = comp_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;

      if (cmd.load) begin
         scan_in = log_ptr_ff;
         comp_in = 1'b0;
      end
      if (cmd.rd_log) scan_in = scan_ff - SW'(1);
      if (cmd.cur_log) cur_in = rdata_ff[31:0];
      if (cmd.cur_base) begin
         if (!base_ok_ff[bank_ff]) begin
            cur_in = feel_pkg::ERASED;
         end else begin
            cur_in = w_ff[0] ? rdata_ff[63:32] : rdata_ff[31:0];
         end
      end
      if (cmd.append) log_ptr_in = log_ptr_ff + SW'(1);
      if (cmd.cp_init) begin
         cp_in   = '0;
         comp_in = 1'b1;
      end
      if (cmd.cp_base_wr || cmd.cp_log_wr) cp_in = cp_ff + SW'(1);
      if (cmd.cp_seq_wr) seq_in = seq_ff + 32'd1;
      if (cmd.cp_magic_wr) begin
         bank_in           = other;
         log_ptr_in        = SW'(BASE_SLOTS);
         base_ok_in[other] = 1'b1;
      end
      if (cmd.respond) rsp_valid_in = 1'b1;
   end

   always_comb begin
      if (cmd_ff == feel_pkg::CMD_READ) begin
         rsp_status_in = feel_pkg::ST_READ;
      end else if (nv == cur_ff) begin
         rsp_status_in = feel_pkg::ST_SKIPPED;
      end else if (comp_ff) begin
         rsp_status_in = feel_pkg::ST_COMPACTED;
      end else begin
         rsp_status_in = feel_pkg::ST_LOGGED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         log_ptr_ff   <= SW'(BASE_SLOTS);
         seq_ff       <= 32'd1;
         base_ok_ff   <= 2'b00;
         scan_ff      <= '0;
         cp_ff        <= '0;
         comp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bank_ff      <= bank_in;
         log_ptr_ff   <= log_ptr_in;
         seq_ff       <= seq_in;
         base_ok_ff   <= base_ok_in;
         scan_ff      <= scan_in;
         cp_ff        <= cp_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.load) begin
         cmd_ff <= req.command;
         w_ff   <= WW'(req.word_index);
         wd_ff  <= req.write_data;
         be_ff  <= req.byte_enable;
      end
      if (cmd.respond) begin
         rsp_data_ff   <= (cmd_ff == feel_pkg::CMD_READ) ? cur_ff : nv;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;
   assign rsp.status    = rsp_status_ff;

   // scan_done doubles as end of the base copy: the counter then sits on the first log slot
   assign stat.scan_done = cmd.cp_base_wr ? (cp_ff == SW'(BASE_SLOTS - 1))
                                          : (scan_ff == SW'(BASE_SLOTS));
   assign stat.hit       = (rdata_ff[47:32] == off16);
   assign stat.is_write  = (cmd_ff == feel_pkg::CMD_WRITE);
   assign stat.unchanged = (nv == cur_ff);
   assign stat.log_full  = (log_ptr_ff == SW'(LOG_LIMIT));
   assign stat.cpl_last  = (cp_ff == log_ptr_ff - SW'(1));
   assign stat.rsp_free  = ~rsp_valid_ff | rsp.ready;

endmodule

### rtl/core/flash_eeprom_emulation_log.sv
// top level of the flash eeprom emulation log
// Emulates a word-addressed EEPROM (EEPROM_BYTES bytes) on an internal two-bank
// flash store; each request reads one 32-bit word or writes its enabled bytes.
// One request is handled at a time; the store has a single read port, and every
// flash read is issued first and its registered data is checked after. A lookup scans
// the log from the newest slot down and stops at the first hit; if no slot holds the
// word it falls back to the base image. A write that changes the word appends a log
// slot. When the log is full a write compacts: each base entry is copied, the log
// slots are replayed into the other bank, then the new word, the sequence number and
// the magic are written. A bank's base image reads as erased until a compaction has
// filled it, and log slots are only read below the log pointer, so no clearing pass
// runs.
// The next request word is accepted while the previous response word still waits.
module flash_eeprom_emulation_log #(
   parameter int EEPROM_BYTES = feel_pkg::EEPROM_BYTES_DEF,
   parameter int BANK_BYTES   = feel_pkg::BANK_BYTES_DEF
) (
   input logic         clock,
   input logic         reset,
   feel_req_if.sink    req_chan,
   feel_rsp_if.source  rsp_chan
);

   // command and status between sequencer and datapath
   feel_pkg::ctrl_cmd_type  cmd;
   feel_pkg::ctrl_stat_type stat;

   // sequencer: lookup, append, compaction and response steps
   feel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_chan.ready),
      .req_valid (req_chan.valid)
   );

   // datapath: flash array, bank pointers, counters and response register
   feel_dpath #(
      .EEPROM_BYTES (EEPROM_BYTES),
      .BANK_BYTES   (BANK_BYTES)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   // never append into a full log
   assert property (@(posedge clock) disable iff (reset) stat.log_full |-> !cmd.append)
      else $error("append into full log");

   // a response word is only loaded when the output register is free
   assert property (@(posedge clock) disable iff (reset) cmd.respond |-> stat.rsp_free)
      else $error("response overwrites pending word");

   // one request in flight: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request accepted while busy");

endmodule

### tb/sv/tb_flash_eeprom_emulation_log.sv
// testbench for the flash eeprom emulation log: predicted word values and status checked per response
module tb_flash_eeprom_emulation_log;

   localparam int WORDS      = feel_pkg::EEPROM_BYTES_DEF / 4;
   localparam int BASE_SLOTS = feel_pkg::EEPROM_BYTES_DEF / 8;
   localparam int BANK_SLOTS = feel_pkg::BANK_BYTES_DEF / 8;
   localparam int LOG_LIMIT  = BANK_SLOTS - 2;
   localparam int LOG_DEPTH  = LOG_LIMIT - BASE_SLOTS;

   typedef struct packed {
      logic        command;
      logic [7:0]  word_index;
      logic [31:0] write_data;
      logic [3:0]  byte_enable;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   feel_req_if req_chan ();
   feel_rsp_if rsp_chan ();

   flash_eeprom_emulation_log uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   // predictor state: the emulated word image and the log fill level
   logic [31:0] eeprom_image [WORDS];
   int          log_fill;

   req_word_type pending_reqs [$];
   rsp_word_type expected_words [$];
   int        error_count = 0;
   int        accepted_rsps = 0;
   bit        quiet_phase = 0;
   int        req_gap = 0;
   int        rsp_stall = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at rsp %0d", what, got, want, accepted_rsps);
      error_count++;
   endtask

   // the log only matters through its fill level; the visible word image is what reads return
   function automatic rsp_word_type predict_word(input req_word_type r);
      rsp_word_type res;
      logic [7:0]  w;
      logic [31:0] cur, mask, nv;
      w = r.word_index & 8'(WORDS - 1);
      cur = eeprom_image[w];
      if (r.command == feel_pkg::CMD_READ) begin
         res.read_data = cur;
         res.status = feel_pkg::ST_READ;
         return res;
      end
      mask = '0;
      for (int k = 0; k < 4; k++)
         if (r.byte_enable[k]) mask[8*k +: 8] = 8'hff;
      nv = (cur & ~mask) | (r.write_data & mask);
      res.read_data = nv;
      if (nv == cur) begin
         res.status = feel_pkg::ST_SKIPPED;
      end else if (log_fill < LOG_DEPTH) begin
         eeprom_image[w] = nv;
         log_fill++;
         res.status = feel_pkg::ST_LOGGED;
      end else begin
         // compaction: new bank starts with an empty log
         eeprom_image[w] = nv;
         log_fill = 0;
         res.status = feel_pkg::ST_COMPACTED;
      end
      return res;
   endfunction

   function automatic req_word_type make_req(input logic cmd, input logic [7:0] idx,
                                             input logic [31:0] data, input logic [3:0] be);
      req_word_type r;
      r.command = cmd;
      r.word_index = idx;
      r.write_data = data;
      r.byte_enable = be;
      return r;
   endfunction

   // driver: one word offered at a time from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.command <= feel_pkg::CMD_READ;
         req_chan.word_index <= '0;
         req_chan.write_data <= '0;
         req_chan.byte_enable <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_words.push_back(predict_word({req_chan.command, req_chan.word_index,
                                                   req_chan.write_data, req_chan.byte_enable}));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_word_type r;
               r = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               {req_chan.command, req_chan.word_index, req_chan.write_data,
                req_chan.byte_enable} <= r;
               if (!quiet_phase && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 11);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each accepted response word, stalls the sink in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_word_type want;
            accepted_rsps++;
            if (expected_words.size() == 0) begin
               report("unexpected word", 64'({rsp_chan.read_data, rsp_chan.status}), '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_chan.read_data !== want.read_data)
                  report("read_data", 64'(rsp_chan.read_data), 64'(want.read_data));
               if (rsp_chan.status !== want.status)
                  report("status", 64'(rsp_chan.status), 64'(want.status));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 4) == 0) rsp_stall = $urandom_range(1, 11);
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [7:0] hot [8];
      for (int i = 0; i < WORDS; i++) eeprom_image[i] = feel_pkg::ERASED;
      log_fill = 0;
      req_chan.valid = 1'b0;
      req_chan.command = feel_pkg::CMD_READ;
      req_chan.word_index = '0;
      req_chan.write_data = '0;
      req_chan.byte_enable = '0;
      rsp_chan.ready = 1'b0;

      // directed: erased reads, lane writes, zero enable, no-change write, index extremes
      pending_reqs.push_back(make_req(feel_pkg::CMD_READ, 8'd0, 32'h0, 4'h0));
      pending_reqs.push_back(make_req(feel_pkg::CMD_READ, 8'd255, 32'hffffffff, 4'hf));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd0, 32'h00000000, 4'hf));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd255, 32'h12345678, 4'h1));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd255, 32'h9abcdef0, 4'h2));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd255, 32'h55aa55aa, 4'h4));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd255, 32'ha5a5a5a5, 4'h8));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd1, 32'h00000000, 4'h0));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd0, 32'h00000000, 4'hf));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd0, 32'hffffffff, 4'hf));
      pending_reqs.push_back(make_req(feel_pkg::CMD_READ, 8'd0, 32'h0, 4'h0));
      pending_reqs.push_back(make_req(feel_pkg::CMD_READ, 8'd255, 32'h0, 4'h0));
      pending_reqs.push_back(make_req(feel_pkg::CMD_WRITE, 8'd128, 32'hdeadbeef, 4'h5));
      pending_reqs.push_back(make_req(feel_pkg::CMD_READ, 8'd128, 32'h0, 4'h0));
      pending_reqs.push_back(make_req(feel_pkg::CMD_READ, 8'd127, 32'h0, 4'h0));

      // random: mostly writes to a small hot set so lookups scan a growing log
      for (int i = 0; i < 8; i++) hot[i] = 8'($urandom);
      for (int i = 0; i < 450; i++) begin
         logic [7:0] idx;
         logic       cmd;
         cmd = ($urandom_range(0, 9) < 8) ? feel_pkg::CMD_WRITE : feel_pkg::CMD_READ;
         idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : hot[$urandom_range(0, 7)];
         pending_reqs.push_back(make_req(cmd, idx, $urandom,
                                         ($urandom_range(0, 15) == 0) ? 4'h0 : 4'($urandom)));
      end
      // read a spread of words back at the end
      for (int i = 0; i < WORDS; i += 7)
         pending_reqs.push_back(make_req(feel_pkg::CMD_READ, 8'(i), 32'h0, 4'h0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() < 100);
      quiet_phase = 1;
      wait (pending_reqs.size() == 0 && !req_chan.valid && expected_words.size() == 0);
      repeat (3000) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("tb_flash_eeprom_emulation_log: clean");
      end else begin
         $display("tb_flash_eeprom_emulation_log: errors");
      end
      $finish;
   end

   // watchdog sized for every request scanning a full log plus stalls and compactions
   initial begin
      #60000000;
      $display("tb_flash_eeprom_emulation_log: errors");
      $finish;
   end

endmodule
